// ===== rtl/core/efs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, heap entry type and helper functions of the
// earliest-free server scheduler. Depends on nothing.
package efs_pkg;

  // Sizing of the server table and of the time arithmetic.
  localparam int MAX_SERVERS = 1024;
  localparam int TIME_BITS   = 48;
  localparam int RATE_BITS   = 16;
  localparam int COUNT_BITS  = 16;

  localparam int ID_W   = $clog2(MAX_SERVERS);
  localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
  localparam int IDX_W  = ID_W + 2;
  localparam int PROD_W = RATE_BITS + COUNT_BITS;
  localparam int SUM_W  = ((TIME_BITS > PROD_W) ? TIME_BITS : PROD_W) + 1;

  // Fixed widths of the channel payloads.
  localparam int IN_RATE_W  = 16;
  localparam int IN_COUNT_W = 16;
  localparam int OUT_ID_W   = 10;
  localparam int OUT_TIME_W = 48;

  localparam logic [TIME_BITS-1:0] TIME_LIMIT = '1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_FULL       = 2'd1;
  localparam logic [1:0] STATUS_NO_SERVERS = 2'd2;

  // Operation codes.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  typedef struct packed {
    logic [TIME_BITS-1:0] free_time;
    logic [ID_W-1:0]      id;
  } entry_t;

  // True when entry a leaves the heap before entry b.
  function automatic logic earlier(entry_t a, entry_t b);
    return (a.free_time < b.free_time) ||
           ((a.free_time == b.free_time) && (a.id < b.id));
  endfunction

  // Fit an internal time onto the result field.
  function automatic logic [OUT_TIME_W-1:0] to_out_time(logic [TIME_BITS-1:0] t);
    logic [63:0] w;
    w = 64'(t);
    return w[OUT_TIME_W-1:0];
  endfunction

  // Fit an internal id onto the result field.
  function automatic logic [OUT_ID_W-1:0] to_out_id(logic [ID_W-1:0] id);
    logic [31:0] w;
    w = 32'(id);
    return w[OUT_ID_W-1:0];
  endfunction

endpackage

// ===== rtl/core/efs_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the earliest-free server
// scheduler. Depends on efs_pkg.
interface efs_req_if import efs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [IN_RATE_W-1:0]  service_rate;
  logic [IN_COUNT_W-1:0] item_count;

  modport source (output valid, output op, output service_rate, output item_count,
                  input ready);
  modport sink   (input valid, input op, input service_rate, input item_count,
                  output ready);
endinterface

interface efs_rsp_if import efs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [OUT_ID_W-1:0]   server_id;
  logic [OUT_TIME_W-1:0] finish_time;
  logic [OUT_TIME_W-1:0] latest_finish;

  modport source (output valid, output status, output server_id, output finish_time,
                  output latest_finish, input ready);
  modport sink   (input valid, input status, input server_id, input finish_time,
                  input latest_finish, output ready);
endinterface

// ===== rtl/core/earliest_free_server_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Earliest-free server scheduler: binary min-heap of servers in a block
// memory. Depends on efs_pkg and on the interfaces in efs_if.sv.
//
// Channel  Dir  Beat carries
// req      in   op, service_rate, item_count
// rsp      out  status, server_id, finish_time, latest_finish
//
// One item at a time; the next beat is taken once its result is registered.
// An add writes its rate, then climbs one level per read and compare of the
// parent. A customer reads the root and its rate, multiplies, adds, then sinks
// one level per read and compare of both children; errors go straight to the
// output. Reset clears the server count and the running maximum; the heap and
// rate memories need no clearing. A stalled response holds in the output
// register while the next item is already worked, then blocks the input.
module earliest_free_server_scheduler_unit
  import efs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  efs_req_if.sink   req,
  efs_rsp_if.source rsp
);

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_UP_RD  = 4'd2;
  localparam logic [3:0] S_UP_CMP = 4'd3;
  localparam logic [3:0] S_ROOT   = 4'd4;
  localparam logic [3:0] S_RATE   = 4'd5;
  localparam logic [3:0] S_ADD    = 4'd6;
  localparam logic [3:0] S_DN_RD  = 4'd7;
  localparam logic [3:0] S_DN_CMP = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state;

  // Latched request.
  logic                  op_r;
  logic [RATE_BITS-1:0]  rate_r;
  logic [COUNT_BITS-1:0] count_r;

  // Heap walk state.
  logic [ID_W-1:0]   pos;
  entry_t            x;
  logic              right_ok;
  logic [PROD_W-1:0] prod;

  // Architectural state.
  logic [CNT_W-1:0]     server_count;
  logic [TIME_BITS-1:0] running_max;

  // Result being built and the output register.
  logic [1:0]            res_status;
  logic [ID_W-1:0]       res_id;
  logic [TIME_BITS-1:0]  res_finish;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic [OUT_ID_W-1:0]   out_id;
  logic [OUT_TIME_W-1:0] out_finish;
  logic [OUT_TIME_W-1:0] out_latest;

  // Memories and their ports.
  entry_t               heap_mem [MAX_SERVERS];
  logic [RATE_BITS-1:0] rate_mem [MAX_SERVERS];
  logic                 heap_we;
  logic [ID_W-1:0]      heap_waddr;
  entry_t               heap_wdata;
  logic [ID_W-1:0]      heap_raddr_a;
  logic [ID_W-1:0]      heap_raddr_b;
  entry_t               rd_a;
  entry_t               rd_b;
  logic                 rate_we;
  logic [ID_W-1:0]      rate_raddr;
  logic [RATE_BITS-1:0] rate_rd;

  // Request fields reduced to their internal widths.
  logic [31:0]           rate_wide;
  logic [31:0]           count_wide;
  logic [RATE_BITS-1:0]  rate_in;
  logic [COUNT_BITS-1:0] count_in;

  assign rate_wide  = 32'(req.service_rate);
  assign count_wide = 32'(req.item_count);
  assign rate_in    = rate_wide[RATE_BITS-1:0];
  assign count_in   = count_wide[COUNT_BITS-1:0];

  // Heap index arithmetic around the current position.
  logic [ID_W-1:0]  parent;
  logic [IDX_W-1:0] left_idx;
  logic [IDX_W-1:0] right_idx;
  logic [IDX_W-1:0] count_ext;
  logic             table_full;

  assign parent     = ID_W'(pos - 1'b1) >> 1;
  assign left_idx   = (IDX_W'(pos) << 1) + IDX_W'(1);
  assign right_idx  = left_idx + IDX_W'(1);
  assign count_ext  = IDX_W'(server_count);
  assign table_full = (server_count == CNT_W'(MAX_SERVERS));

  // Saturating time update.
  logic [SUM_W-1:0]     sum;
  logic [TIME_BITS-1:0] t_new;

  assign sum   = SUM_W'(x.free_time) + SUM_W'(prod);
  assign t_new = (sum > SUM_W'(TIME_LIMIT)) ? TIME_LIMIT : sum[TIME_BITS-1:0];

  // Child selection for the sift-down step.
  logic l_lt_x;
  logic r_lt_x;
  logic r_lt_l;
  logic pick_r;
  logic pick_l;

  assign l_lt_x = earlier(rd_a, x);
  assign r_lt_x = earlier(rd_b, x);
  assign r_lt_l = earlier(rd_b, rd_a);
  assign pick_r = right_ok && (l_lt_x ? r_lt_l : r_lt_x);
  assign pick_l = l_lt_x && !pick_r;

  logic out_free;
  assign out_free = !out_valid || rsp.ready;

  // Memory port control.
  always_comb begin
    heap_we      = 1'b0;
    heap_waddr   = pos;
    heap_wdata   = x;
    heap_raddr_a = '0;
    heap_raddr_b = '0;
    rate_we      = 1'b0;
    rate_raddr   = rd_a.id;
    case (state)
      S_START: begin
        if (op_r == OP_ADD && !table_full) begin
          rate_we = 1'b1;
        end
      end
      S_UP_RD: begin
        if (pos == '0) begin
          heap_we = 1'b1;
        end else begin
          heap_raddr_a = parent;
        end
      end
      S_UP_CMP: begin
        heap_we = 1'b1;
        if (rd_a.free_time != '0) begin
          heap_wdata = rd_a;
        end
      end
      S_DN_RD: begin
        if (left_idx >= count_ext) begin
          heap_we = 1'b1;
        end else begin
          heap_raddr_a = left_idx[ID_W-1:0];
          heap_raddr_b = right_idx[ID_W-1:0];
        end
      end
      S_DN_CMP: begin
        heap_we = 1'b1;
        if (pick_r) begin
          heap_wdata = rd_b;
        end else if (pick_l) begin
          heap_wdata = rd_a;
        end
      end
      default: begin
      end
    endcase
  end

  // Heap memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    rd_a <= heap_mem[heap_raddr_a];
    rd_b <= heap_mem[heap_raddr_b];
  end

  // Rate memory: written at the new id, read at the top server's id.
  always_ff @(posedge clk) begin
    if (rate_we) begin
      rate_mem[server_count[ID_W-1:0]] <= rate_r;
    end
    rate_rd <= rate_mem[rate_raddr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      server_count <= '0;
      running_max  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r    <= req.op;
            rate_r  <= rate_in;
            count_r <= count_in;
            state   <= S_START;
          end
        end
        S_START: begin
          res_id     <= '0;
          res_finish <= '0;
          res_status <= STATUS_OK;
          if (op_r == OP_ADD) begin
            if (table_full) begin
              res_status <= STATUS_FULL;
              state      <= S_OUT;
            end else begin
              pos          <= server_count[ID_W-1:0];
              x.free_time  <= '0;
              x.id         <= server_count[ID_W-1:0];
              res_id       <= server_count[ID_W-1:0];
              server_count <= server_count + 1'b1;
              state        <= S_UP_RD;
            end
          end else begin
            if (server_count == '0) begin
              res_status <= STATUS_NO_SERVERS;
              state      <= S_OUT;
            end else begin
              state <= S_ROOT;
            end
          end
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_OUT : S_UP_CMP;
        end
        S_UP_CMP: begin
          // The new server has free time zero, so it climbs past any busy parent.
          if (rd_a.free_time != '0) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_ROOT: begin
          x     <= rd_a;
          state <= S_RATE;
        end
        S_RATE: begin
          prod  <= PROD_W'(rate_rd) * PROD_W'(count_r);
          state <= S_ADD;
        end
        S_ADD: begin
          x.free_time <= t_new;
          res_finish  <= t_new;
          res_id      <= x.id;
          if (t_new > running_max) begin
            running_max <= t_new;
          end
          pos   <= '0;
          state <= S_DN_RD;
        end
        S_DN_RD: begin
          right_ok <= (right_idx < count_ext);
          state    <= (left_idx >= count_ext) ? S_OUT : S_DN_CMP;
        end
        S_DN_CMP: begin
          if (pick_r) begin
            pos   <= right_idx[ID_W-1:0];
            state <= S_DN_RD;
          end else if (pick_l) begin
            pos   <= left_idx[ID_W-1:0];
            state <= S_DN_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_id     <= to_out_id(res_id);
            out_finish <= to_out_time(res_finish);
            out_latest <= to_out_time(running_max);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.server_id     = out_id;
  assign rsp.finish_time   = out_finish;
  assign rsp.latest_finish = out_latest;

  // The server count never passes the table size.
  assert property (@(posedge clk) disable iff (rst)
    server_count <= CNT_W'(MAX_SERVERS))
    else $error("server count beyond table size");

  // The running maximum never falls.
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> running_max >= $past(running_max))
    else $error("running maximum decreased");

  // Every walk position names a live heap slot.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DN_RD || state == S_UP_RD) |-> (CNT_W'(pos) < server_count))
    else $error("heap position outside live entries");

  // A reported finish time never exceeds the reported maximum.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.finish_time <= rsp.latest_finish))
    else $error("finish time above latest finish");

endmodule
